/* hdl/fmrg_pkg.sv */
`default_nettype none

package fmrg_pkg;

  // Bin storage: four 16-bit bins in each 64-bit register, eight slots in all.
  localparam int MAX_BINS_DEF = 8;
  localparam int SLOTS        = 8;
  localparam int SLOTS_PER_W  = 4;
  localparam int BIN_W        = 16;
  localparam int CNT_W        = 4;
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int SRC_W        = 16;

  // Arithmetic widths: ratio <= 5, eight bins of 16 bits -> total < 2^22.
  localparam int RAT_W   = 3;
  localparam int PROD_W  = BIN_W + RAT_W;
  localparam int TOT_W   = 22;
  localparam int NUM_W   = TOT_W + 2;
  localparam int Q_FRAC  = 16;
  localparam int QB      = Q_FRAC + 1;
  localparam int DIV_CNT_W = 5;
  localparam int POS_W   = 18;
  localparam int TEX_W   = 19;
  localparam int QUAD_N  = 4;
  localparam int QUAD_W  = 2;

  localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LO  = 3'd0,
    CFG_X_HI  = 3'd1,
    CFG_Y_LO  = 3'd2,
    CFG_Y_HI  = 3'd3,
    CFG_X_CNT = 3'd4,
    CFG_Y_CNT = 3'd5,
    CFG_SRC_W = 3'd6,
    CFG_SRC_H = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QUAD,
    ST_SUM,
    ST_YSTART,
    ST_DIV_TOP,
    ST_DIV_BOT,
    ST_XSTART,
    ST_DIV_X,
    ST_EMIT_TOP,
    ST_EMIT_BOT,
    ST_EMIT_END
  } state_t;

  typedef enum logic [1:0] {
    DSEL_TOP,
    DSEL_BOT,
    DSEL_X
  } div_sel_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_QUAD,
    EMIT_TOP,
    EMIT_BOT,
    EMIT_END
  } emit_t;

  typedef struct packed {
    logic     init;
    logic     sum_step;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_top;
    logic     cap_bot;
    logic     x_advance;
    logic     quad_step;
    emit_t    emit;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic row_oob;
    logic sum_last;
    logic quad_last;
    logic x_last;
    logic div_done;
  } stat_t;

  // Expansion ratio of bin i out of n: |(n-1)/2 - i| + 1.
  function automatic logic [RAT_W-1:0] ratio(input logic [CNT_W-1:0] n,
                                             input logic [CNT_W-1:0] i);
    logic [CNT_W-1:0] mid;
    logic [CNT_W-1:0] d;
    mid = (n == '0) ? '0 : ((n - CNT_W'(1)) >> 1);
    d   = (mid >= i) ? (mid - i) : (i - mid);
    return RAT_W'(d + CNT_W'(1));
  endfunction

endpackage

`default_nettype wire

/* hdl/fmrg_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle: sign(num) * (|num| << 16) / max(1,den).
module fmrg_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [fmrg_pkg::NUM_W-1:0]   num,
  input  logic        [fmrg_pkg::TOT_W-1:0]   den,
  output logic                                done,
  output logic signed [fmrg_pkg::POS_W-1:0]   res
);

  logic                              busy_r;
  logic                              done_r;
  logic [fmrg_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [fmrg_pkg::TOT_W:0]          rem_r;
  logic [fmrg_pkg::TOT_W-1:0]        den_r;
  logic [fmrg_pkg::QB-1:0]           q_r;
  logic                              neg_r;

  logic [fmrg_pkg::NUM_W-1:0]        mag;
  logic                              ge;
  logic [fmrg_pkg::TOT_W:0]          rem_sub;

  assign mag     = num[fmrg_pkg::NUM_W-1] ? (-num) : num;
  assign ge      = rem_r >= {1'b0, den_r};
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= fmrg_pkg::DIV_CNT_W'(fmrg_pkg::QB);
    end else if (busy_r) begin
      cnt_r <= cnt_r - fmrg_pkg::DIV_CNT_W'(1);
      if (cnt_r == fmrg_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[fmrg_pkg::NUM_W-1];
      rem_r <= {1'b0, mag[fmrg_pkg::TOT_W-1:0]};
      den_r <= (den == '0) ? fmrg_pkg::TOT_W'(1) : den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= {rem_sub[fmrg_pkg::TOT_W-1:0], 1'b0};
      q_r   <= {q_r[fmrg_pkg::QB-2:0], ge};
    end
  end

  assign done = done_r;
  assign res  = neg_r ? (-fmrg_pkg::POS_W'(q_r)) : fmrg_pkg::POS_W'(q_r);

endmodule

`default_nettype wire

/* hdl/fmrg_dp.sv */
`default_nettype none

module fmrg_dp #(
  parameter int MAX_BINS = fmrg_pkg::MAX_BINS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [fmrg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fmrg_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic [2:0]                            in_row,
  input  fmrg_pkg::cmd_t                        cmd,
  output fmrg_pkg::stat_t                       stat,
  output logic                                  out_valid,
  output logic signed [fmrg_pkg::POS_W-1:0]     out_pos_x,
  output logic signed [fmrg_pkg::POS_W-1:0]     out_pos_y,
  output logic [fmrg_pkg::TEX_W-1:0]            out_tex_u,
  output logic [fmrg_pkg::TEX_W-1:0]            out_tex_v,
  output logic                                  out_last_vertex
);

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int XJ_W  = $clog2(MAX_BINS + 1);

  // Configuration registers
  logic [fmrg_pkg::CFG_W-1:0] x_lo_r, x_hi_r, y_lo_r, y_hi_r;
  logic [fmrg_pkg::CNT_W-1:0] x_cnt_r, y_cnt_r;
  logic [fmrg_pkg::SRC_W-1:0] src_w_r, src_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lo_r  <= '0;
      x_hi_r  <= '0;
      y_lo_r  <= '0;
      y_hi_r  <= '0;
      x_cnt_r <= '0;
      y_cnt_r <= '0;
      src_w_r <= '0;
      src_h_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fmrg_pkg::CFG_X_LO:  x_lo_r  <= cfg_wdata;
        fmrg_pkg::CFG_X_HI:  x_hi_r  <= cfg_wdata;
        fmrg_pkg::CFG_Y_LO:  y_lo_r  <= cfg_wdata;
        fmrg_pkg::CFG_Y_HI:  y_hi_r  <= cfg_wdata;
        fmrg_pkg::CFG_X_CNT: x_cnt_r <= cfg_wdata[fmrg_pkg::CNT_W-1:0];
        fmrg_pkg::CFG_Y_CNT: y_cnt_r <= cfg_wdata[fmrg_pkg::CNT_W-1:0];
        fmrg_pkg::CFG_SRC_W: src_w_r <= cfg_wdata[fmrg_pkg::SRC_W-1:0];
        fmrg_pkg::CFG_SRC_H: src_h_r <= cfg_wdata[fmrg_pkg::SRC_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack bins and clamp counts
  logic [fmrg_pkg::BIN_W-1:0] xbin [MAX_BINS];
  logic [fmrg_pkg::BIN_W-1:0] ybin [MAX_BINS];

  always_comb begin
    for (int i = 0; i < MAX_BINS; i++) begin
      if (i < fmrg_pkg::SLOTS_PER_W) begin
        xbin[i] = x_lo_r[fmrg_pkg::BIN_W*(i % fmrg_pkg::SLOTS_PER_W) +: fmrg_pkg::BIN_W];
        ybin[i] = y_lo_r[fmrg_pkg::BIN_W*(i % fmrg_pkg::SLOTS_PER_W) +: fmrg_pkg::BIN_W];
      end else begin
        xbin[i] = x_hi_r[fmrg_pkg::BIN_W*(i % fmrg_pkg::SLOTS_PER_W) +: fmrg_pkg::BIN_W];
        ybin[i] = y_hi_r[fmrg_pkg::BIN_W*(i % fmrg_pkg::SLOTS_PER_W) +: fmrg_pkg::BIN_W];
      end
    end
  end

  logic [fmrg_pkg::CNT_W-1:0] nx, ny;
  assign nx = (x_cnt_r > fmrg_pkg::CNT_W'(MAX_BINS)) ? fmrg_pkg::CNT_W'(MAX_BINS) : x_cnt_r;
  assign ny = (y_cnt_r > fmrg_pkg::CNT_W'(MAX_BINS)) ? fmrg_pkg::CNT_W'(MAX_BINS) : y_cnt_r;

  // Sequencing counters and row accumulators
  logic [IDX_W-1:0]            idx_r;
  logic [XJ_W-1:0]             xj_r;
  logic [fmrg_pkg::QUAD_W-1:0] quad_r;
  logic [2:0]                  row_r;
  logic [fmrg_pkg::TOT_W-1:0]  tot_x_r, tot_y_r, acc_x_r, acc_y_r;
  logic [fmrg_pkg::PROD_W-1:0] ry_bin_r;
  logic [fmrg_pkg::BIN_W-1:0]  bin_y_r;
  logic [fmrg_pkg::TEX_W-1:0]  in_x_r, in_y_r;
  logic signed [fmrg_pkg::POS_W-1:0] top_r, bot_r;

  logic [IDX_W-1:0]            x_idx;
  logic [fmrg_pkg::PROD_W-1:0] prod_x, prod_y;
  logic [fmrg_pkg::CNT_W-1:0]  idx_ext, row_ext;

  assign x_idx   = cmd.sum_step ? idx_r : xj_r[IDX_W-1:0];
  assign idx_ext = fmrg_pkg::CNT_W'(idx_r);
  assign row_ext = fmrg_pkg::CNT_W'(row_r);
  assign prod_x  = fmrg_pkg::PROD_W'(fmrg_pkg::ratio(nx, fmrg_pkg::CNT_W'(x_idx)))
                 * fmrg_pkg::PROD_W'(xbin[x_idx]);
  assign prod_y  = fmrg_pkg::PROD_W'(fmrg_pkg::ratio(ny, idx_ext))
                 * fmrg_pkg::PROD_W'(ybin[idx_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      xj_r   <= '0;
      quad_r <= '0;
      row_r  <= '0;
    end else if (cmd.init) begin
      idx_r  <= '0;
      xj_r   <= '0;
      quad_r <= '0;
      row_r  <= in_row;
    end else begin
      if (cmd.sum_step)  idx_r  <= idx_r + IDX_W'(1);
      if (cmd.x_advance) xj_r   <= xj_r + XJ_W'(1);
      if (cmd.quad_step) quad_r <= quad_r + fmrg_pkg::QUAD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      tot_x_r <= '0;
      tot_y_r <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      in_x_r  <= '0;
      in_y_r  <= '0;
    end else begin
      if (cmd.sum_step) begin
        if (idx_ext < nx) tot_x_r <= tot_x_r + fmrg_pkg::TOT_W'(prod_x);
        if (idx_ext < ny) tot_y_r <= tot_y_r + fmrg_pkg::TOT_W'(prod_y);
        if (idx_ext < row_ext) begin
          acc_y_r <= acc_y_r + fmrg_pkg::TOT_W'(prod_y);
          in_y_r  <= in_y_r + fmrg_pkg::TEX_W'(ybin[idx_r]);
        end
      end
      if (cmd.x_advance) begin
        acc_x_r <= acc_x_r + fmrg_pkg::TOT_W'(prod_x);
        in_x_r  <= in_x_r + fmrg_pkg::TEX_W'(xbin[x_idx]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_step && (idx_ext == row_ext)) begin
      ry_bin_r <= prod_y;
      bin_y_r  <= ybin[idx_r];
    end
  end

  // Shared divider
  logic [fmrg_pkg::TOT_W-1:0]        acc_bot;
  logic signed [fmrg_pkg::NUM_W-1:0] num_top, num_bot, num_x, div_num;
  logic [fmrg_pkg::TOT_W-1:0]        div_den;
  logic                              div_done;
  logic signed [fmrg_pkg::POS_W-1:0] div_res;

  assign acc_bot = acc_y_r + fmrg_pkg::TOT_W'(ry_bin_r);
  assign num_top = $signed({2'b00, tot_y_r}) - $signed({1'b0, acc_y_r, 1'b0});
  assign num_bot = $signed({2'b00, tot_y_r}) - $signed({1'b0, acc_bot, 1'b0});
  assign num_x   = $signed({1'b0, acc_x_r, 1'b0}) - $signed({2'b00, tot_x_r});

  always_comb begin
    unique case (cmd.div_sel)
      fmrg_pkg::DSEL_TOP: begin
        div_num = num_top;
        div_den = tot_y_r;
      end
      fmrg_pkg::DSEL_BOT: begin
        div_num = num_bot;
        div_den = tot_y_r;
      end
      fmrg_pkg::DSEL_X: begin
        div_num = num_x;
        div_den = tot_x_r;
      end
      default: begin
        div_num = num_x;
        div_den = tot_x_r;
      end
    endcase
  end

  fmrg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_top) top_r <= div_res;
    if (cmd.cap_bot) bot_r <= div_res;
  end

  // Status back to the controller
  assign stat.trivial   = (nx <= fmrg_pkg::CNT_W'(1)) && (ny <= fmrg_pkg::CNT_W'(1));
  assign stat.row_oob   = fmrg_pkg::CNT_W'(in_row) >= ny;
  assign stat.sum_last  = idx_r == IDX_W'(MAX_BINS - 1);
  assign stat.quad_last = quad_r == fmrg_pkg::QUAD_W'(fmrg_pkg::QUAD_N - 1);
  assign stat.x_last    = fmrg_pkg::CNT_W'(xj_r) == nx;
  assign stat.div_done  = div_done;

  // Output register
  logic                              out_valid_r;
  logic signed [fmrg_pkg::POS_W-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [fmrg_pkg::TEX_W-1:0]        tex_u_r, tex_u_nxt, tex_v_r, tex_v_nxt;
  logic                              last_r, last_nxt;
  logic [fmrg_pkg::TEX_W-1:0]        v_bot;

  assign v_bot = in_y_r + fmrg_pkg::TEX_W'(bin_y_r);

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    tex_u_nxt = tex_u_r;
    tex_v_nxt = tex_v_r;
    last_nxt  = last_r;
    unique case (cmd.emit)
      fmrg_pkg::EMIT_QUAD: begin
        pos_x_nxt = quad_r[0] ? fmrg_pkg::POS_ONE : -fmrg_pkg::POS_ONE;
        pos_y_nxt = quad_r[1] ? fmrg_pkg::POS_ONE : -fmrg_pkg::POS_ONE;
        tex_u_nxt = quad_r[0] ? fmrg_pkg::TEX_W'(src_w_r) : '0;
        tex_v_nxt = quad_r[1] ? '0 : fmrg_pkg::TEX_W'(src_h_r);
        last_nxt  = stat.quad_last;
      end
      fmrg_pkg::EMIT_TOP: begin
        pos_x_nxt = div_res;
        pos_y_nxt = top_r;
        tex_u_nxt = in_x_r;
        tex_v_nxt = in_y_r;
        last_nxt  = 1'b0;
      end
      fmrg_pkg::EMIT_BOT: begin
        pos_x_nxt = div_res;
        pos_y_nxt = bot_r;
        tex_u_nxt = in_x_r;
        tex_v_nxt = v_bot;
        last_nxt  = 1'b0;
      end
      fmrg_pkg::EMIT_END: begin
        pos_x_nxt = div_res;
        pos_y_nxt = bot_r;
        tex_u_nxt = in_x_r;
        tex_v_nxt = v_bot;
        last_nxt  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit != fmrg_pkg::EMIT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r <= pos_x_nxt;
    pos_y_r <= pos_y_nxt;
    tex_u_r <= tex_u_nxt;
    tex_v_r <= tex_v_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = pos_x_r;
  assign out_pos_y       = pos_y_r;
  assign out_tex_u       = tex_u_r;
  assign out_tex_v       = tex_v_r;
  assign out_last_vertex = last_r;

endmodule

`default_nettype wire

/* hdl/fmrg_ctrl.sv */
`default_nettype none

module fmrg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  fmrg_pkg::stat_t   stat,
  output fmrg_pkg::cmd_t    cmd,
  output logic              busy
);

  fmrg_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fmrg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fmrg_pkg::ST_IDLE: begin
        if (start) begin
          priority if (stat.trivial) state_nxt = fmrg_pkg::ST_QUAD;
          else if (stat.row_oob)     state_nxt = fmrg_pkg::ST_IDLE;
          else                       state_nxt = fmrg_pkg::ST_SUM;
        end
      end
      fmrg_pkg::ST_QUAD:
        if (stat.quad_last) state_nxt = fmrg_pkg::ST_IDLE;
      fmrg_pkg::ST_SUM:
        if (stat.sum_last) state_nxt = fmrg_pkg::ST_YSTART;
      fmrg_pkg::ST_YSTART:
        state_nxt = fmrg_pkg::ST_DIV_TOP;
      fmrg_pkg::ST_DIV_TOP:
        if (stat.div_done) state_nxt = fmrg_pkg::ST_DIV_BOT;
      fmrg_pkg::ST_DIV_BOT:
        if (stat.div_done) state_nxt = fmrg_pkg::ST_XSTART;
      fmrg_pkg::ST_XSTART:
        state_nxt = fmrg_pkg::ST_DIV_X;
      fmrg_pkg::ST_DIV_X:
        if (stat.div_done) state_nxt = fmrg_pkg::ST_EMIT_TOP;
      fmrg_pkg::ST_EMIT_TOP:
        state_nxt = fmrg_pkg::ST_EMIT_BOT;
      fmrg_pkg::ST_EMIT_BOT:
        state_nxt = stat.x_last ? fmrg_pkg::ST_EMIT_END : fmrg_pkg::ST_XSTART;
      fmrg_pkg::ST_EMIT_END:
        state_nxt = fmrg_pkg::ST_IDLE;
      default:
        state_nxt = fmrg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.init      = 1'b0;
    cmd.sum_step  = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = fmrg_pkg::DSEL_X;
    cmd.cap_top   = 1'b0;
    cmd.cap_bot   = 1'b0;
    cmd.x_advance = 1'b0;
    cmd.quad_step = 1'b0;
    cmd.emit      = fmrg_pkg::EMIT_NONE;
    busy          = 1'b1;
    unique case (state_r)
      fmrg_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.init = start;
      end
      fmrg_pkg::ST_QUAD: begin
        cmd.emit      = fmrg_pkg::EMIT_QUAD;
        cmd.quad_step = 1'b1;
      end
      fmrg_pkg::ST_SUM: begin
        cmd.sum_step  = 1'b1;
      end
      fmrg_pkg::ST_YSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = fmrg_pkg::DSEL_TOP;
      end
      fmrg_pkg::ST_DIV_TOP: begin
        cmd.cap_top   = stat.div_done;
        cmd.div_start = stat.div_done;
        cmd.div_sel   = fmrg_pkg::DSEL_BOT;
      end
      fmrg_pkg::ST_DIV_BOT: begin
        cmd.cap_bot = stat.div_done;
      end
      fmrg_pkg::ST_XSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = fmrg_pkg::DSEL_X;
      end
      fmrg_pkg::ST_DIV_X: ;
      fmrg_pkg::ST_EMIT_TOP: begin
        cmd.emit = fmrg_pkg::EMIT_TOP;
      end
      fmrg_pkg::ST_EMIT_BOT: begin
        cmd.emit      = fmrg_pkg::EMIT_BOT;
        cmd.x_advance = !stat.x_last;
      end
      fmrg_pkg::ST_EMIT_END: begin
        cmd.emit = fmrg_pkg::EMIT_END;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/foveation_mesh_row_generator_core.sv */
`default_nettype none

// Channel   Ports                                           Beat taken when
// -------   ---------------------------------------------   -------------------------
// command   start, busy, in_row                             start && !busy
// vertex    out_valid, out_pos_x/y, out_tex_u/v,            out_valid (one cycle,
//           out_last_vertex                                 no backpressure)
// config    cfg_we, cfg_index, cfg_wdata                    cfg_we
//
// Sequence: a trivial mesh (both bin counts <= 1) sends its four quad vertices. A regular
// row sums all MAX_BINS bin slots, runs the divisions for the row's top and bottom y,
// then for each of nx+1 x columns launches a division and sends two vertex beats, and
// ends with the doubled end vertex. All divisions share one bit-serial divider. The last
// beat comes in the same cycle as busy falls. A row at or past the y bin count is
// accepted and, unless the mesh is trivial, produces nothing. Reset is synchronous,
// active low, and clears all configuration to zero. The vertex receiver cannot stall;
// each beat is shown for exactly one cycle.
module foveation_mesh_row_generator_core #(
  parameter int MAX_BINS = fmrg_pkg::MAX_BINS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            in_row,
  output logic                                  out_valid,
  output logic signed [fmrg_pkg::POS_W-1:0]     out_pos_x,
  output logic signed [fmrg_pkg::POS_W-1:0]     out_pos_y,
  output logic [fmrg_pkg::TEX_W-1:0]            out_tex_u,
  output logic [fmrg_pkg::TEX_W-1:0]            out_tex_v,
  output logic                                  out_last_vertex,
  input  logic                                  cfg_we,
  input  logic [fmrg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fmrg_pkg::CFG_W-1:0]            cfg_wdata
);

  fmrg_pkg::cmd_t  cmd;
  fmrg_pkg::stat_t stat;

  // Controller: walks sum -> y divisions -> per-column division and vertex beats, or emits the quad.
  fmrg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: config registers, accumulators, shared divider, vertex register.
  fmrg_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_row          (in_row),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_last_vertex (out_last_vertex)
  );

`ifndef NO_ASSERTIONS
  // Any beat that is not the last of its command arrives while the block is busy.
  a_mid_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_vertex) |-> busy)
    else $error("non-final vertex beat while idle");

  // Busy rises only because a command was taken.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // A freshly launched division never reports completion on the next cycle.
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !stat.div_done)
    else $error("divider finished too early");
`endif

endmodule

`default_nettype wire

/* bench/foveation_mesh_row_generator_core_tb.sv */
`timescale 1ns / 100ps

module foveation_mesh_row_generator_core_tb;

  // Quiet cycles after the last vertex before the block counts as idle:
  // bin summing, two y divisions and one column per bin plus the end column.
  localparam int SETTLE_CYCLES = 46 + 21 * (fmrg_pkg::MAX_BINS_DEF + 1) + 20;
  // Abort after this many cycles with no beat on any port.
  localparam int QUIET_LIMIT   = 5000;
  localparam int DIR_N         = 21;

  // One vertex beat as it leaves the block.
  typedef struct packed {
    logic signed [fmrg_pkg::POS_W-1:0] pos_x;
    logic signed [fmrg_pkg::POS_W-1:0] pos_y;
    logic [fmrg_pkg::TEX_W-1:0]        tex_u;
    logic [fmrg_pkg::TEX_W-1:0]        tex_v;
    logic                              last;
  } vertex_t;

  // How a directed row gets its expectation.
  typedef enum logic [1:0] {
    CHK_PREDICT,  // computed from the shadow registers
    CHK_QUAD,     // fullscreen quad, typed in
    CHK_SILENT    // row past the y bin count: no vertex at all
  } check_t;

  typedef enum logic [3:0] {
    SET_RESET,
    SET_QUAD_MAX,
    SET_FULL_MAX,
    SET_NO_X,
    SET_CLAMP,
    SET_ZERO_BINS,
    SET_ONE_X,
    SET_ONE_Y
  } setting_t;

  typedef struct packed {
    setting_t   setting;
    logic [2:0] row;
    check_t     chk;
  } dir_entry_t;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic [2:0]                        in_row;
  logic                              out_valid;
  logic signed [fmrg_pkg::POS_W-1:0] out_pos_x;
  logic signed [fmrg_pkg::POS_W-1:0] out_pos_y;
  logic [fmrg_pkg::TEX_W-1:0]        out_tex_u;
  logic [fmrg_pkg::TEX_W-1:0]        out_tex_v;
  logic                              out_last_vertex;
  logic                              cfg_we;
  logic [fmrg_pkg::CFG_IDX_W-1:0]    cfg_index;
  logic [fmrg_pkg::CFG_W-1:0]        cfg_wdata;

  // Register images: staged holds the next setting, shadow what the block holds.
  logic [fmrg_pkg::CFG_W-1:0] staged [fmrg_pkg::SLOTS];
  logic [fmrg_pkg::CFG_W-1:0] shadow [fmrg_pkg::SLOTS];

  vertex_t    pending_vertices [$];
  dir_entry_t directed_tbl [DIR_N];
  int         error_count;
  int         vertex_seen;
  int         quiet_cycles;

  foveation_mesh_row_generator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_row          (in_row),
    .out_valid       (out_valid),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_last_vertex (out_last_vertex),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Predictor of the vertex strip
  // ------------------------------------------------------------------

  function automatic logic [fmrg_pkg::BIN_W-1:0] bin_value(
      input logic [fmrg_pkg::CFG_W-1:0] lo,
      input logic [fmrg_pkg::CFG_W-1:0] hi,
      input int i);
    logic [fmrg_pkg::CFG_W-1:0] w;
    w = (i < fmrg_pkg::SLOTS_PER_W) ? lo : hi;
    return w[fmrg_pkg::BIN_W * (i % fmrg_pkg::SLOTS_PER_W) +: fmrg_pkg::BIN_W];
  endfunction

  function automatic longint x_bin(input int i);
    return longint'(bin_value(shadow[fmrg_pkg::CFG_X_LO], shadow[fmrg_pkg::CFG_X_HI], i));
  endfunction

  function automatic longint y_bin(input int i);
    return longint'(bin_value(shadow[fmrg_pkg::CFG_Y_LO], shadow[fmrg_pkg::CFG_Y_HI], i));
  endfunction

  // Counts above the bin capacity saturate.
  function automatic int bins_in_use(input logic [fmrg_pkg::CFG_W-1:0] c);
    int n;
    n = int'(c[fmrg_pkg::CNT_W-1:0]);
    return (n > fmrg_pkg::MAX_BINS_DEF) ? fmrg_pkg::MAX_BINS_DEF : n;
  endfunction

  // Bins stretch more the further they sit from the center bin.
  function automatic longint stretch(input int n, input int i);
    int mid;
    int d;
    mid = (n == 0) ? 0 : (n - 1) / 2;
    d   = mid - i;
    if (d < 0) d = -d;
    return longint'(d + 1);
  endfunction

  // Map num/total to Q1.16, truncating toward zero; a total below 1 is taken as 1.
  function automatic logic signed [fmrg_pkg::POS_W-1:0] to_q16(input longint num,
                                                               input longint total);
    longint den;
    longint mag;
    longint q;
    den = (total < 1) ? 1 : total;
    mag = (num < 0) ? -num : num;
    q   = (mag * 65536) / den;
    return fmrg_pkg::POS_W'((num < 0) ? -q : q);
  endfunction

  function automatic void push_vertex(input longint px, input longint py,
                                      input longint u, input longint v,
                                      input logic last);
    vertex_t vx;
    vx.pos_x = fmrg_pkg::POS_W'(px);
    vx.pos_y = fmrg_pkg::POS_W'(py);
    vx.tex_u = fmrg_pkg::TEX_W'(u);
    vx.tex_v = fmrg_pkg::TEX_W'(v);
    vx.last  = last;
    pending_vertices.push_back(vx);
  endfunction

  // Fullscreen quad from the current source size.
  function automatic void push_quad();
    longint sw;
    longint sh;
    sw = longint'(shadow[fmrg_pkg::CFG_SRC_W][fmrg_pkg::SRC_W-1:0]);
    sh = longint'(shadow[fmrg_pkg::CFG_SRC_H][fmrg_pkg::SRC_W-1:0]);
    push_vertex(-65536, -65536, 0, sh, 1'b0);
    push_vertex(65536, -65536, sw, sh, 1'b0);
    push_vertex(-65536, 65536, 0, 0, 1'b0);
    push_vertex(65536, 65536, sw, 0, 1'b1);
  endfunction

  // Queue every vertex that a request for this row must produce.
  function automatic void strip_for_row(input logic [2:0] row);
    int     nx;
    int     ny;
    int     r;
    longint tot_x;
    longint tot_y;
    longint acc_x;
    longint acc_y;
    longint tex_x;
    longint tex_y;
    longint bin_y;
    longint top;
    longint bot;
    longint px;
    longint b;
    nx    = bins_in_use(shadow[fmrg_pkg::CFG_X_CNT]);
    ny    = bins_in_use(shadow[fmrg_pkg::CFG_Y_CNT]);
    r     = int'(row);
    tot_x = 0;
    tot_y = 0;
    acc_x = 0;
    acc_y = 0;
    tex_x = 0;
    tex_y = 0;

    // Trivial mesh: the fullscreen quad, regardless of row.
    if (nx <= 1 && ny <= 1) begin
      push_quad();
      return;
    end
    if (r >= ny) return;

    for (int i = 0; i < nx; i++) tot_x += stretch(nx, i) * x_bin(i);
    for (int i = 0; i < ny; i++) tot_y += stretch(ny, i) * y_bin(i);
    for (int i = 0; i < r; i++) begin
      b      = y_bin(i);
      acc_y += stretch(ny, i) * b;
      tex_y += b;
    end

    bin_y = y_bin(r);
    top   = to_q16(tot_y - 2 * acc_y, tot_y);
    bot   = to_q16(tot_y - 2 * (acc_y + stretch(ny, r) * bin_y), tot_y);

    for (int i = 0; i < nx; i++) begin
      b  = x_bin(i);
      px = to_q16(2 * acc_x - tot_x, tot_x);
      push_vertex(px, top, tex_x, tex_y, 1'b0);
      push_vertex(px, bot, tex_x, tex_y + bin_y, 1'b0);
      tex_x += b;
      acc_x += stretch(nx, i) * b;
    end
    // End column, its bottom vertex doubled to close the strip.
    px = to_q16(2 * acc_x - tot_x, tot_x);
    push_vertex(px, top, tex_x, tex_y, 1'b0);
    push_vertex(px, bot, tex_x, tex_y + bin_y, 1'b0);
    push_vertex(px, bot, tex_x, tex_y + bin_y, 1'b1);
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input longint got,
                               input longint want);
    error_count++;
    $display("MISMATCH vertex %0d %s: got %0d expected %0d",
             vertex_seen, what, got, want);
  endtask

  // Write all eight registers from staged, one beat per cycle.
  task automatic program_regs();
    for (int i = 0; i < fmrg_pkg::SLOTS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= fmrg_pkg::CFG_IDX_W'(i);
      cfg_wdata <= staged[i];
      unique case (fmrg_pkg::cfg_reg_t'(i))
        fmrg_pkg::CFG_X_CNT, fmrg_pkg::CFG_Y_CNT: begin
          shadow[i] = fmrg_pkg::CFG_W'(staged[i][fmrg_pkg::CNT_W-1:0]);
        end
        fmrg_pkg::CFG_SRC_W, fmrg_pkg::CFG_SRC_H: begin
          shadow[i] = fmrg_pkg::CFG_W'(staged[i][fmrg_pkg::SRC_W-1:0]);
        end
        default: shadow[i] = staged[i];
      endcase
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Drop start, drain every pending vertex, then give a row that
  // produces nothing time to finish before touching the registers.
  task automatic settle();
    start <= 1'b0;
    while (pending_vertices.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Present one command beat; hold it until the block takes it.
  task automatic send_row(input logic [2:0] row, input int idle_pct,
                          input check_t chk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    start  <= 1'b1;
    in_row <= row;
    do @(posedge clk); while (busy);
    unique case (chk)
      CHK_PREDICT: strip_for_row(row);
      CHK_QUAD:    push_quad();
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic directed_regs(input setting_t id);
    unique case (id)
      SET_QUAD_MAX: begin
        // Trivial mesh with every bin and both sizes at full scale.
        for (int i = 0; i < 4; i++) staged[i] = '1;
        staged[fmrg_pkg::CFG_X_CNT] = 64'd1;
        staged[fmrg_pkg::CFG_Y_CNT] = 64'd0;
        staged[fmrg_pkg::CFG_SRC_W] = 64'hFFFF;
        staged[fmrg_pkg::CFG_SRC_H] = 64'hFFFF;
      end
      SET_FULL_MAX: begin
        for (int i = 0; i < 4; i++) staged[i] = '1;
        staged[fmrg_pkg::CFG_X_CNT] = 64'd8;
        staged[fmrg_pkg::CFG_Y_CNT] = 64'd8;
        staged[fmrg_pkg::CFG_SRC_W] = 64'd0;
        staged[fmrg_pkg::CFG_SRC_H] = 64'd0;
      end
      SET_NO_X: begin
        // No x bins: three end vertices per row at zero x.
        staged[fmrg_pkg::CFG_X_LO]  = 64'h1111_2222_3333_4444;
        staged[fmrg_pkg::CFG_X_HI]  = 64'h5555_6666_7777_8888;
        staged[fmrg_pkg::CFG_Y_LO]  = 64'h0004_0003_0002_0001;
        staged[fmrg_pkg::CFG_Y_HI]  = 64'hFFFF_0100_0010_0000;
        staged[fmrg_pkg::CFG_X_CNT] = 64'd0;
        staged[fmrg_pkg::CFG_Y_CNT] = 64'd8;
        staged[fmrg_pkg::CFG_SRC_W] = 64'h8000;
        staged[fmrg_pkg::CFG_SRC_H] = 64'h0001;
      end
      SET_CLAMP: begin
        // Counts past capacity, junk in the upper data bits.
        staged[fmrg_pkg::CFG_X_LO]  = 64'h1234_5678_9ABC_DEF0;
        staged[fmrg_pkg::CFG_X_HI]  = 64'h0FED_CBA9_8765_4321;
        staged[fmrg_pkg::CFG_Y_LO]  = 64'hAAAA_5555_0001_FFFE;
        staged[fmrg_pkg::CFG_Y_HI]  = 64'h0000_7FFF_8000_0003;
        staged[fmrg_pkg::CFG_X_CNT] = 64'hFFFF_FFFF_FFFF_FFFF;
        staged[fmrg_pkg::CFG_Y_CNT] = 64'hA5A5_0000_0000_0009;
        staged[fmrg_pkg::CFG_SRC_W] = 64'hDEAD_0000_0000_1234;
        staged[fmrg_pkg::CFG_SRC_H] = 64'h0000_BEEF_0000_4321;
      end
      SET_ZERO_BINS: begin
        // Zero totals: every position collapses to 0.
        for (int i = 0; i < 4; i++) staged[i] = '0;
        staged[fmrg_pkg::CFG_X_CNT] = 64'd3;
        staged[fmrg_pkg::CFG_Y_CNT] = 64'd2;
        staged[fmrg_pkg::CFG_SRC_W] = 64'd7;
        staged[fmrg_pkg::CFG_SRC_H] = 64'd9;
      end
      SET_ONE_X: begin
        staged[fmrg_pkg::CFG_X_LO]  = 64'h0000_0000_0000_0040;
        staged[fmrg_pkg::CFG_X_HI]  = 64'h0000_0000_0000_0000;
        staged[fmrg_pkg::CFG_Y_LO]  = 64'h0000_0000_0030_0010;
        staged[fmrg_pkg::CFG_Y_HI]  = 64'h0000_0000_0000_0000;
        staged[fmrg_pkg::CFG_X_CNT] = 64'd1;
        staged[fmrg_pkg::CFG_Y_CNT] = 64'd2;
        staged[fmrg_pkg::CFG_SRC_W] = 64'd100;
        staged[fmrg_pkg::CFG_SRC_H] = 64'd200;
      end
      SET_ONE_Y: begin
        staged[fmrg_pkg::CFG_X_LO]  = 64'h0000_0000_0005_0003;
        staged[fmrg_pkg::CFG_X_HI]  = 64'hFFFF_FFFF_FFFF_FFFF;
        staged[fmrg_pkg::CFG_Y_LO]  = 64'h0000_0000_0000_0011;
        staged[fmrg_pkg::CFG_Y_HI]  = 64'hFFFF_FFFF_FFFF_FFFF;
        staged[fmrg_pkg::CFG_X_CNT] = 64'd2;
        staged[fmrg_pkg::CFG_Y_CNT] = 64'd1;
        staged[fmrg_pkg::CFG_SRC_W] = 64'd1;
        staged[fmrg_pkg::CFG_SRC_H] = 64'd1;
      end
      default: ;
    endcase
  endtask

  // Bins lean toward the edges of the range and toward small counts.
  function automatic logic [fmrg_pkg::BIN_W-1:0] pick_bin();
    unique case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return fmrg_pkg::BIN_W'($urandom_range(15));
      default: return fmrg_pkg::BIN_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [fmrg_pkg::CFG_W-1:0] pick_count();
    logic [fmrg_pkg::CFG_W-1:0] w;
    int                         r;
    w = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 8)       w[fmrg_pkg::CNT_W-1:0] = fmrg_pkg::CNT_W'($urandom_range(1));
    else if (r < 16) w[fmrg_pkg::CNT_W-1:0] = fmrg_pkg::CNT_W'($urandom_range(15, 9));
    else             w[fmrg_pkg::CNT_W-1:0] = fmrg_pkg::CNT_W'($urandom_range(8, 2));
    return w;
  endfunction

  task automatic randomize_regs();
    for (int w = 0; w < 4; w++)
      for (int s = 0; s < fmrg_pkg::SLOTS_PER_W; s++)
        staged[w][fmrg_pkg::BIN_W * s +: fmrg_pkg::BIN_W] = pick_bin();
    staged[fmrg_pkg::CFG_X_CNT] = pick_count();
    staged[fmrg_pkg::CFG_Y_CNT] = pick_count();
    // Now and then force the trivial mesh.
    if ($urandom_range(9) == 0) begin
      staged[fmrg_pkg::CFG_X_CNT][fmrg_pkg::CNT_W-1:0] = fmrg_pkg::CNT_W'($urandom_range(1));
      staged[fmrg_pkg::CFG_Y_CNT][fmrg_pkg::CNT_W-1:0] = fmrg_pkg::CNT_W'($urandom_range(1));
    end
    staged[fmrg_pkg::CFG_SRC_W] = {$urandom, $urandom};
    staged[fmrg_pkg::CFG_SRC_H] = {$urandom, $urandom};
  endtask

  // Mostly rows inside the y bin range, the rest anywhere.
  function automatic logic [2:0] pick_row();
    int n;
    n = bins_in_use(shadow[fmrg_pkg::CFG_Y_CNT]);
    if (n > 0 && $urandom_range(9) < 8) return 3'($urandom_range(n - 1));
    return 3'($urandom_range(7));
  endfunction

  // ------------------------------------------------------------------
  // Vertex checker: compare each beat with the oldest pending vertex
  // ------------------------------------------------------------------
  always @(posedge clk) begin : vertex_check
    vertex_t want;
    if (rst_n && out_valid) begin
      if (pending_vertices.size() == 0) begin
        flag_mismatch("beat with nothing pending, pos_x", out_pos_x, 0);
      end else begin
        want = pending_vertices.pop_front();
        if (out_pos_x !== want.pos_x) flag_mismatch("pos_x", out_pos_x, want.pos_x);
        if (out_pos_y !== want.pos_y) flag_mismatch("pos_y", out_pos_y, want.pos_y);
        if (out_tex_u !== want.tex_u) flag_mismatch("tex_u", out_tex_u, want.tex_u);
        if (out_tex_v !== want.tex_v) flag_mismatch("tex_v", out_tex_v, want.tex_v);
        if (out_last_vertex !== want.last)
          flag_mismatch("last_vertex", out_last_vertex, want.last);
      end
      vertex_seen++;
    end
  end

  // Watchdog: any beat on any port clears it.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) quiet_cycles <= 0;
    else                                         quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin : main_seq
    setting_t cur_setting;
    int       idle_pct;
    int       n_rows;

    error_count  = 0;
    vertex_seen  = 0;
    quiet_cycles = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_row       = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    for (int i = 0; i < fmrg_pkg::SLOTS; i++) begin
      staged[i] = '0;
      shadow[i] = '0;
    end

    // Directed rows, grouped by register setting. Quad and silent rows
    // carry their expectation in the table itself.
    directed_tbl = '{
      '{SET_RESET,     3'd0, CHK_QUAD},
      '{SET_RESET,     3'd5, CHK_QUAD},
      '{SET_QUAD_MAX,  3'd0, CHK_QUAD},
      '{SET_QUAD_MAX,  3'd7, CHK_QUAD},
      '{SET_FULL_MAX,  3'd0, CHK_PREDICT},
      '{SET_FULL_MAX,  3'd3, CHK_PREDICT},
      '{SET_FULL_MAX,  3'd7, CHK_PREDICT},
      '{SET_NO_X,      3'd0, CHK_PREDICT},
      '{SET_NO_X,      3'd7, CHK_PREDICT},
      '{SET_CLAMP,     3'd0, CHK_PREDICT},
      '{SET_CLAMP,     3'd5, CHK_PREDICT},
      '{SET_CLAMP,     3'd7, CHK_PREDICT},
      '{SET_ZERO_BINS, 3'd0, CHK_PREDICT},
      '{SET_ZERO_BINS, 3'd1, CHK_PREDICT},
      '{SET_ZERO_BINS, 3'd2, CHK_SILENT},
      '{SET_ZERO_BINS, 3'd7, CHK_SILENT},
      '{SET_ONE_X,     3'd1, CHK_PREDICT},
      '{SET_ONE_X,     3'd3, CHK_SILENT},
      '{SET_ONE_Y,     3'd0, CHK_PREDICT},
      '{SET_ONE_Y,     3'd1, CHK_SILENT},
      '{SET_ONE_Y,     3'd6, CHK_SILENT}
    };

    // Hold reset, then release it on a falling edge.
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cur_setting = SET_RESET;
    for (int i = 0; i < DIR_N; i++) begin
      if (directed_tbl[i].setting != cur_setting) begin
        settle();
        cur_setting = directed_tbl[i].setting;
        directed_regs(cur_setting);
        program_regs();
      end
      send_row(directed_tbl[i].row, 11, directed_tbl[i].chk);
    end

    // Random rows: sender idles rarely, often, then never. Each phase
    // walks through several random register settings.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 11 : (phase == 1) ? 60 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        settle();
        randomize_regs();
        program_regs();
        n_rows = $urandom_range(16, 10);
        for (int k = 0; k < n_rows; k++) send_row(pick_row(), idle_pct, CHK_PREDICT);
      end
    end

    // Drain and let the last row run out before deciding.
    settle();
    if (error_count == 0) $display("RESULT: OK");
    else                  $display("RESULT: ERROR");
    $finish;
  end

endmodule
